// File: rtl/psw_pkg.sv
// Shared types, command/status structs and helpers for the priority scheduler.
package psw_pkg;

  localparam int unsigned BURST_W = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned NUM_W   = 6;
  localparam int unsigned TIME_W  = 21;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Input transaction payload
  typedef struct packed {
    logic [BURST_W-1:0] burst_time;
    logic [PRIO_W-1:0]  job_priority;
    logic               last_job;
  } psw_in_t;

  // Result transaction payload
  typedef struct packed {
    logic [NUM_W-1:0]   job_number;
    logic [PRIO_W-1:0]  row_priority;
    logic [BURST_W-1:0] row_burst;
    logic [TIME_W-1:0]  waiting_time;
    logic [TIME_W-1:0]  turnaround_time;
    logic [TIME_W-1:0]  avg_waiting;
    logic [TIME_W-1:0]  avg_turnaround;
    logic               last_row;
  } psw_out_t;

  // One job slot in the job memory
  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [NUM_W-1:0]   num;
  } psw_entry_t;

  localparam int unsigned ENTRY_W = $bits(psw_entry_t);

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_TOTAL,
    ST_DIV,
    ST_EMIT_RD,
    ST_EMIT_LD
  } psw_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic ld_job;      // store accepted job
    logic start;       // last job seen: latch batch size, clear counters
    logic scan_issue;  // sort scan: read slot j
    logic swap_a;      // write minimum into slot i
    logic swap_b;      // write old slot i into minimum's slot, advance i
    logic tot_init;    // clear accumulators for the totals pass
    logic tot_issue;   // totals pass: read slot j
    logic div_init;    // load both dividers
    logic div_step;    // one quotient bit
    logic emit_init;   // clear row index and running wait
    logic emit_rd;     // read slot j for output
    logic emit_ld;     // load output register
  } psw_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic j_end;      // j has reached the batch size
    logic rd_pend;    // a scan/totals read is in flight
    logic i_last;     // after this swap only one slot remains
    logic n_zero;     // batch being started is empty
    logic n_one;      // batch being started holds one job
    logic div_done;   // all quotient bits produced
    logic out_free;   // output register can take a row this cycle
    logic emit_last;  // row being loaded is the last one
  } psw_sts_t;

  // Clamp to the 21-bit time range
  function automatic logic [TIME_W-1:0] sat_time(input logic [31:0] v);
    logic [TIME_W-1:0] r;
    if (v > 32'(TIME_MAX)) begin
      r = TIME_MAX;
    end else begin
      r = v[TIME_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/psw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psw_ram
  #(parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1)
  (input  logic             clk,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/psw_ctrl.sv
// Sequencer for load, sort, totals, divide and row emission phases.
module psw_ctrl
  import psw_pkg::*;
  (input  logic     clk,
   input  logic     rst_n,
   input  logic     in_valid,
   input  logic     in_last,
   output logic     in_ready,
   output psw_cmd_t cmd,
   input  psw_sts_t sts);

  psw_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_job = 1'b1;
          if (in_last) begin
            cmd.start = 1'b1;
            priority if (sts.n_zero) begin
              state_nxt = ST_LOAD;
            end else if (sts.n_one) begin
              cmd.tot_init = 1'b1;
              state_nxt    = ST_TOTAL;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = !sts.j_end;
        if (sts.j_end && !sts.rd_pend) begin
          state_nxt = ST_SWAP_A;
        end
      end
      ST_SWAP_A: begin
        cmd.swap_a = 1'b1;
        state_nxt  = ST_SWAP_B;
      end
      ST_SWAP_B: begin
        cmd.swap_b = 1'b1;
        if (sts.i_last) begin
          cmd.tot_init = 1'b1;
          state_nxt    = ST_TOTAL;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_TOTAL: begin
        cmd.tot_issue = !sts.j_end;
        if (sts.j_end && !sts.rd_pend) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.emit_init = 1'b1;
          state_nxt     = ST_EMIT_RD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          state_nxt   = sts.emit_last ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

// File: rtl/psw_dp.sv
// Datapath: job memory, sort scan, totals, dividers and output register.
module psw_dp
  import psw_pkg::*;
  #(parameter int unsigned MAX_PROCS = 32)
  (input  logic     clk,
   input  logic     rst_n,
   input  psw_in_t  in_data,
   input  psw_cmd_t cmd,
   output psw_sts_t sts,
   output logic     out_valid,
   input  logic     out_ready,
   output psw_out_t out_data);

  localparam int unsigned CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int unsigned IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned WAIT_W = BURST_W + CNT_W;
  localparam int unsigned TOT_W  = WAIT_W + CNT_W;
  localparam int unsigned DIVC_W = $clog2(TOT_W + 1);

  // Control and payload registers
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  psw_entry_t        cur_r, cur_nxt;
  psw_entry_t        min_r, min_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              rd_tot_r, rd_tot_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  logic [TOT_W-1:0]  tw_r, tw_nxt;
  logic [TOT_W-1:0]  tt_r, tt_nxt;
  logic [TOT_W-1:0]  qw_r, qw_nxt;
  logic [TOT_W-1:0]  qt_r, qt_nxt;
  logic [CNT_W:0]    rw_r, rw_nxt;
  logic [CNT_W:0]    rt_r, rt_nxt;
  logic [DIVC_W-1:0] divc_r, divc_nxt;
  logic              out_valid_r, out_valid_nxt;
  psw_out_t          out_data_r, out_data_nxt;

  // Memory ports
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  psw_entry_t        ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  psw_entry_t        rd_ent;

  // Helper signals
  logic              stored;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  n_load;
  logic [WAIT_W-1:0] burst_ext;
  logic [WAIT_W-1:0] wait_plus;
  logic [CNT_W:0]    rw_sh, rt_sh, n_ext;
  logic              ge_w, ge_t;

  assign rd_ent    = psw_entry_t'(ram_rdata);
  assign stored    = (count_r < CNT_W'(MAX_PROCS));
  assign cnt_inc   = count_r + CNT_W'(1);
  assign n_load    = stored ? cnt_inc : count_r;
  assign burst_ext = WAIT_W'(rd_ent.burst);
  assign wait_plus = wait_r + burst_ext;

  // Restoring divider step, one bit per cycle for both totals
  assign n_ext = {1'b0, n_r};
  assign rw_sh = {rw_r[CNT_W-1:0], qw_r[TOT_W-1]};
  assign rt_sh = {rt_r[CNT_W-1:0], qt_r[TOT_W-1]};
  assign ge_w  = (rw_sh >= n_ext);
  assign ge_t  = (rt_sh >= n_ext);

  // Memory port muxing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[IDX_W-1:0];
    ram_wdata = '{burst: in_data.burst_time, prio: in_data.job_priority,
                  num: NUM_W'(cnt_inc)};
    priority if (cmd.ld_job && stored) begin
      ram_we = 1'b1;
    end else if (cmd.swap_a) begin
      ram_we    = 1'b1;
      ram_waddr = i_r;
      ram_wdata = min_r;
    end else if (cmd.swap_b) begin
      ram_we    = 1'b1;
      ram_waddr = pos_r;
      ram_wdata = cur_r;
    end
    ram_re    = cmd.scan_issue | cmd.tot_issue | cmd.emit_rd;
    ram_raddr = j_r[IDX_W-1:0];
  end

  // Next-state logic
  always_comb begin
    count_nxt     = count_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    min_nxt       = min_r;
    rd_vld_nxt    = cmd.scan_issue | cmd.tot_issue;
    rd_tot_nxt    = cmd.tot_issue;
    rd_idx_nxt    = j_r[IDX_W-1:0];
    wait_nxt      = wait_r;
    tw_nxt        = tw_r;
    tt_nxt        = tt_r;
    qw_nxt        = qw_r;
    qt_nxt        = qt_r;
    rw_nxt        = rw_r;
    rt_nxt        = rt_r;
    divc_nxt      = divc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    // Loading
    if (cmd.ld_job && stored) begin
      count_nxt = cnt_inc;
    end
    if (cmd.start) begin
      count_nxt = '0;
      n_nxt     = n_load;
      i_nxt     = '0;
      j_nxt     = '0;
    end

    // Sort scan: issue reads, compare returned slots
    if (cmd.scan_issue) begin
      j_nxt = j_r + CNT_W'(1);
    end
    if (rd_vld_r && !rd_tot_r) begin
      if (rd_idx_r == i_r) begin
        cur_nxt = rd_ent;
        min_nxt = rd_ent;
        pos_nxt = rd_idx_r;
      end else if (rd_ent.prio < min_r.prio) begin
        min_nxt = rd_ent;
        pos_nxt = rd_idx_r;
      end
    end
    if (cmd.swap_b) begin
      i_nxt = i_r + IDX_W'(1);
      j_nxt = CNT_W'(i_r) + CNT_W'(1);
    end

    // Totals pass
    if (cmd.tot_init) begin
      j_nxt    = '0;
      wait_nxt = '0;
      tw_nxt   = '0;
      tt_nxt   = '0;
    end
    if (cmd.tot_issue) begin
      j_nxt = j_r + CNT_W'(1);
    end
    if (rd_vld_r && rd_tot_r) begin
      tw_nxt   = tw_r + TOT_W'(wait_r);
      tt_nxt   = tt_r + TOT_W'(wait_plus);
      wait_nxt = wait_plus;
    end

    // Averages
    if (cmd.div_init) begin
      qw_nxt   = tw_r;
      qt_nxt   = tt_r;
      rw_nxt   = '0;
      rt_nxt   = '0;
      divc_nxt = DIVC_W'(TOT_W);
    end
    if (cmd.div_step) begin
      rw_nxt   = ge_w ? (rw_sh - n_ext) : rw_sh;
      rt_nxt   = ge_t ? (rt_sh - n_ext) : rt_sh;
      qw_nxt   = {qw_r[TOT_W-2:0], ge_w};
      qt_nxt   = {qt_r[TOT_W-2:0], ge_t};
      divc_nxt = divc_r - DIVC_W'(1);
    end

    // Row emission
    if (cmd.emit_init) begin
      j_nxt    = '0;
      wait_nxt = '0;
    end
    if (cmd.emit_ld) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.job_number      = rd_ent.num;
      out_data_nxt.row_priority    = rd_ent.prio;
      out_data_nxt.row_burst       = rd_ent.burst;
      out_data_nxt.waiting_time    = sat_time(32'(wait_r));
      out_data_nxt.turnaround_time = sat_time(32'(wait_plus));
      out_data_nxt.avg_waiting     = sat_time(32'(qw_r));
      out_data_nxt.avg_turnaround  = sat_time(32'(qt_r));
      out_data_nxt.last_row        = sts.emit_last;
      wait_nxt                     = wait_plus;
      j_nxt                        = j_r + CNT_W'(1);
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    pos_r      <= pos_nxt;
    cur_r      <= cur_nxt;
    min_r      <= min_nxt;
    rd_tot_r   <= rd_tot_nxt;
    rd_idx_r   <= rd_idx_nxt;
    wait_r     <= wait_nxt;
    tw_r       <= tw_nxt;
    tt_r       <= tt_nxt;
    qw_r       <= qw_nxt;
    qt_r       <= qt_nxt;
    rw_r       <= rw_nxt;
    rt_r       <= rt_nxt;
    divc_r     <= divc_nxt;
    out_data_r <= out_data_nxt;
  end

  // Status to controller
  always_comb begin
    sts.j_end     = (j_r == n_r);
    sts.rd_pend   = rd_vld_r;
    sts.i_last    = ((CNT_W'(i_r) + CNT_W'(1)) == (n_r - CNT_W'(1)));
    sts.n_zero    = (n_load == '0);
    sts.n_one     = (n_load == CNT_W'(1));
    sts.div_done  = (divc_r == '0);
    sts.out_free  = !out_valid_r || out_ready;
    sts.emit_last = ((j_r + CNT_W'(1)) == n_r);
  end

  // Job memory
  psw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PROCS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/priority_schedule_wait_times.sv
// Nonpreemptive priority scheduler: top level joining controller and datapath.
//
// Jobs load one per cycle into a MAX_PROCS-deep job memory; the transaction
// with last_job set closes the batch (jobs past MAX_PROCS are dropped). The
// batch of n jobs is then selection-sorted by ascending priority (first strict
// minimum wins, not stable), totals are summed, both averages are formed by a
// bit-serial divider, and one row per job is sent in schedule order. After the
// closing transaction the block is busy for the scan, swap and totals passes,
// the divider and the row emission, plus any output stall; the quadratic scan
// through the single memory read port dominates. in_ready is high only while
// loading, and the final row may still wait in the output register while the
// next batch loads.
module priority_schedule_wait_times
  import psw_pkg::*;
  #(parameter int unsigned MAX_PROCS = 32)
  (input  logic     clk,
   input  logic     rst_n,
   input  logic     in_valid,
   output logic     in_ready,
   input  psw_in_t  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output psw_out_t out_data);

  psw_cmd_t cmd;
  psw_sts_t sts;

  // Sequencer
  psw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_job),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath
  psw_dp #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
